@@ rtl/core/bfs_pkg.sv @@
// Shared types and constants for the bounded FIFO with search unit.
// No dependencies; imported by every module of the block except bfs_ram.
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_SRCH = 2'd2,
    KIND_STAT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    take;        // latch the request's value
    logic    enq_write;   // write at tail, advance tail, bump count
    logic    deq_pop;     // advance head, drop count
    logic    scan_start;  // start the scan at the newest entry
    logic    scan_step;   // step the scan one entry toward the oldest
    logic    out_load;    // load the result register
    status_t out_status;
    logic    out_data_sel;
    logic    out_pos_sel;
  } bfs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic hit;
    logic scan_last;
    logic out_free;
  } bfs_sts_t;

endpackage

@@ rtl/core/bfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module bfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/bfs_ctrl.sv @@
// Controller state machine for the bounded FIFO with search unit.
// Depends on bfs_pkg for the state, command and status types.
`timescale 1ns / 1ps

module bfs_ctrl import bfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kind_t    in_kind,
  input  bfs_sts_t sts,
  output bfs_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.take = 1'b1;
          unique case (in_kind)
            KIND_ENQ: begin
              cmd.out_load = 1'b1;
              if (sts.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.enq_write  = 1'b1;
                cmd.out_status = ST_OK;
              end
            end
            KIND_DEQ: begin
              if (sts.count_zero) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                state_nxt = S_DEQ;
              end
            end
            KIND_SRCH: begin
              if (sts.count_zero) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            KIND_STAT: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        cmd.deq_pop      = 1'b1;
        cmd.out_load     = 1'b1;
        cmd.out_status   = ST_OK;
        cmd.out_data_sel = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = ST_OK;
          cmd.out_pos_sel = 1'b1;
          state_nxt       = S_IDLE;
        end else if (sts.scan_last) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/bfs_dp.sv @@
// Datapath: queue storage, head/tail/count, scan counter and result register.
// Depends on bfs_pkg and instantiates bfs_ram.
`timescale 1ns / 1ps

module bfs_dp import bfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bfs_cmd_t                 cmd,
  output bfs_sts_t                 sts,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [POS_W-1:0]         out_position,
  output logic [POS_W-1:0]         out_occupancy,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r;
  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] rd_data;
  logic [CNT_W-1:0]  rd_off;
  logic [SUM_W-1:0]  rd_sum;
  logic [SUM_W-1:0]  rd_wrap;
  logic [IDX_W-1:0]  rd_addr;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [DATA_W-1:0]        out_data_r;
  logic [POS_W-1:0]         out_pos_r;
  logic [POS_W-1:0]         out_occ_r;
  logic                     out_empty_r;
  logic                     out_full_r;

  // Enqueue writes in the accepting cycle, so take the word straight from the request
  bfs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.enq_write),
    .wr_addr (tail_r),
    .wr_data (in_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read offset from head: newest entry on scan start, one older per step,
  // head itself otherwise (dequeue).
  always_comb begin
    if (cmd.scan_start) begin
      rd_off = count_r - CNT_W'(1);
    end else if (cmd.scan_step) begin
      rd_off = k_r - CNT_W'(2);
    end else begin
      rd_off = '0;
    end
    rd_sum  = SUM_W'(head_r) + SUM_W'(rd_off);
    rd_wrap = (rd_sum >= SUM_W'(CAPACITY)) ? (rd_sum - SUM_W'(CAPACITY)) : rd_sum;
    rd_addr = rd_wrap[IDX_W-1:0];
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.enq_write) begin
      tail_nxt  = (tail_r == IDX_W'(CAPACITY - 1)) ? '0 : tail_r + IDX_W'(1);
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq_pop) begin
      head_nxt  = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + IDX_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      value_r <= in_value;
    end
    if (cmd.scan_start) begin
      k_r <= count_r;
    end else if (cmd.scan_step) begin
      k_r <= k_r - CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_data_r   <= cmd.out_data_sel ? rd_data : '0;
      out_pos_r    <= cmd.out_pos_sel ? POS_W'(k_r) : '0;
      out_occ_r    <= POS_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == CNT_W'(CAPACITY));
    end
  end

  always_comb begin
    sts.count_zero = (count_r == '0);
    sts.full       = (count_r >= CNT_W'(CAPACITY));
    sts.hit        = (rd_data == value_r);
    sts.scan_last  = (k_r == CNT_W'(1));
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data_out  = out_data_r;
  assign out_position  = out_pos_r;
  assign out_occupancy = out_occ_r;
  assign out_is_empty  = out_empty_r;
  assign out_is_full   = out_full_r;

endmodule

@@ rtl/core/bounded_fifo_with_search_unit.sv @@
// Top level of the bounded FIFO with search unit.
// Depends on bfs_pkg; instantiates bfs_ctrl and bfs_dp.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  ----------------------------------------
//  request   in         in_valid / in_ready   in_kind[1:0], in_value[31:0] signed
//  result    out        out_valid / out_ready out_status[1:0], out_data_out[31:0],
//                                             out_position[4:0], out_occupancy[4:0],
//                                             out_is_empty, out_is_full
//
//  Enqueue, status query and any request on an empty queue are answered from the idle state.
//  Dequeue passes through S_DEQ for one registered RAM read of the head slot.
//  Search reads one RAM entry per cycle, newest first, and stops on the first
//  match or after the oldest entry.
//  A new request is taken only when the result register is free or being drained.
//  Reset (rst_n low, synchronous) empties the queue; the RAM needs no clearing pass.

module bounded_fifo_with_search_unit import bfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [POS_W-1:0]         out_position,
  output logic [POS_W-1:0]         out_occupancy,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  bfs_cmd_t cmd;
  bfs_sts_t sts;

  // Sequencer: decode the request, hold dequeue for the RAM read, walk the scan
  bfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (kind_t'(in_kind)),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, pointers, scan counter and the result register
  bfs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_position  (out_position),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

endmodule

@@ tb/sv/tb_bounded_fifo_with_search_unit.sv @@
// Self-checking testbench for the bounded FIFO with search unit: directed corner
// requests, then weighted random bursts, all results checked against a local predictor.
// Depends on bfs_pkg and bounded_fifo_with_search_unit.
`timescale 1ns / 1ps

module tb_bounded_fifo_with_search_unit;
  import bfs_pkg::*;

  localparam int TOTAL_REQUESTS  = 725;     // directed part plus about 700 random
  localparam int HOLD_OFF_CYCLES = 400;     // long receiver stall that backs the block up
  localparam int SETTLE_CYCLES   = 40;      // quiet margin after the last result before the verdict
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 10;

  // One result as it leaves the block
  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   data_out;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    occupancy;
    logic                is_empty;
    logic                is_full;
  } fifo_result_t;

  // Scoreboard: mirrors the queue, predicts each result at request acceptance
  // and checks the results in order.
  class fifo_search_scoreboard;
    logic [DATA_W-1:0] slots [CAPACITY];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       count;
    fifo_result_t      awaited_results [$];
    int unsigned       mismatches;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      mismatches = 0;
    endfunction

    // Apply one request to the mirrored queue and queue up its result.
    function void note_request(kind_t kind, logic [DATA_W-1:0] value);
      fifo_result_t r;
      int unsigned  k;
      r = '0;
      r.status = ST_OK;
      case (kind)
        KIND_ENQ: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slots[tail] = value;
            tail = (tail + 1) % CAPACITY;
            count++;
          end
        end
        KIND_DEQ: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data_out = slots[head];
            head = (head + 1) % CAPACITY;
            count--;
          end
        end
        KIND_SRCH: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // newest first; the first hit wins, so duplicates report the newest copy
            r.status = ST_MISS;
            for (k = count; k >= 1; k--) begin
              if (slots[(head + k - 1) % CAPACITY] == value) begin
                r.status = ST_OK;
                r.position = POS_W'(k);
                break;
              end
            end
          end
        end
        default: ;
      endcase
      r.occupancy = POS_W'(count);
      r.is_empty  = (count == 0);
      r.is_full   = (count == CAPACITY);
      awaited_results.push_back(r);
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d data=%h pos=%0d occ=%0d",
                   $realtime, got.status, got.data_out, got.position, got.occupancy);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.data_out !== want.data_out ||
          got.position !== want.position || got.occupancy !== want.occupancy ||
          got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch exp status=%0d data=%h pos=%0d occ=%0d empty=%b full=%b",
                   $realtime, want.status, want.data_out, want.position, want.occupancy,
                   want.is_empty, want.is_full);
          $display("%0t:          got status=%0d data=%h pos=%0d occ=%0d empty=%b full=%b",
                   $realtime, got.status, got.data_out, got.position, got.occupancy,
                   got.is_empty, got.is_full);
        end
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function int unsigned failures();
      return mismatches + awaited_results.size();
    endfunction

    function int unsigned occupancy();
      return count;
    endfunction

    // Word at position idx counted from the oldest entry, idx < occupancy
    function logic [DATA_W-1:0] stored_word(int unsigned idx);
      return slots[(head + idx) % CAPACITY];
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_kind;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_data_out;
  logic [POS_W-1:0]         out_position;
  logic [POS_W-1:0]         out_occupancy;
  logic                     out_is_empty;
  logic                     out_is_full;

  fifo_search_scoreboard sb;
  int unsigned           requests_sent;
  int unsigned           cycle_count;
  bit                    hold_off_req;

  bounded_fifo_with_search_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_position  (out_position),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every result at the edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{status_t'(out_status), out_data_out, out_position, out_occupancy,
                        out_is_empty, out_is_full});
  end

  // Short stalls mostly, a few long ones.
  function automatic int unsigned stall_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: toggle ready in calm and busy phases; honor a hold-off request by
  // dropping ready until the hold-off stall counted here runs out.
  initial begin : result_drain
    int unsigned stall_left;
    int unsigned phase_left;
    bit          calm;
    stall_left = 0;
    phase_left = 0;
    calm = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) stall_left = stall_length();
      end
    end
  end

  // Drive one request at the falling edge and hold it until the block takes it.
  task automatic send_request(kind_t kind, logic [DATA_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, value);
    requests_sent++;
  endtask

  // Drop valid and scramble the value for an idle gap; an n of zero keeps requests back to back.
  task automatic idle_for(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_value <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random, a small range for duplicates, or an extreme; most searches reuse a stored word.
  function automatic logic [DATA_W-1:0] pick_value(kind_t kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (kind == KIND_SRCH && sb.occupancy() > 0 && r < 60)
      return sb.stored_word($urandom_range(0, sb.occupancy() - 1));
    if (r < 60) return $urandom;
    if (r < 85) return $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Corner requests: operations on an empty queue, a full fill with extremes and a
  // duplicate, enqueue on a full queue, oldest/duplicate/missing searches.
  task automatic run_directed();
    logic [DATA_W-1:0] fill_words [CAPACITY];
    int unsigned       i;
    for (i = 0; i < CAPACITY; i++) fill_words[i] = 32'h1000_0000 + i;
    fill_words[0]  = 32'h8000_0000;
    fill_words[1]  = 32'h7FFF_FFFF;
    fill_words[2]  = 32'h0000_0000;
    fill_words[3]  = 32'hFFFF_FFFF;
    fill_words[5]  = 32'h0000_0005;
    fill_words[11] = 32'h0000_0005;
    send_request(KIND_DEQ, 32'h1234_5678);
    send_request(KIND_SRCH, 32'h0000_0000);
    send_request(KIND_STAT, 32'hFFFF_FFFF);
    for (i = 0; i < CAPACITY; i++) send_request(KIND_ENQ, fill_words[i]);
    send_request(KIND_ENQ, 32'hDEAD_BEEF);
    send_request(KIND_STAT, 32'h0000_0000);
    send_request(KIND_SRCH, 32'h8000_0000);
    send_request(KIND_SRCH, 32'h0000_0005);
    send_request(KIND_SRCH, 32'h1357_9BDF);
    send_request(KIND_DEQ, 32'h0000_0000);
  endtask

  initial begin : stimulus
    int unsigned burst_kind;
    int unsigned burst_len;
    int unsigned r;
    int unsigned i;
    bit          sender_calm;
    bit          pressure_done;
    bit          pause_done;
    kind_t       kind;

    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_STAT;
    in_value = '0;
    requests_sent = 0;
    cycle_count = 0;
    hold_off_req = 1'b0;
    pressure_done = 1'b0;
    pause_done = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    idle_for(1);
    wait_all_results();

    // Random bursts: fill runs, drain runs and mixed traffic, so the queue
    // swings between empty and full and the indices wrap many times.
    while (requests_sent < TOTAL_REQUESTS) begin
      if (!pressure_done && requests_sent >= 300) begin
        // Stall the result side while requests keep coming.
        hold_off_req = 1'b1;
        pressure_done = 1'b1;
      end
      if (!pause_done && requests_sent >= 520) begin
        idle_for(1);
        wait_all_results();
        pause_done = 1'b1;
      end
      burst_kind = $urandom_range(0, 9);
      burst_len = $urandom_range(4, 24);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < burst_len; i++) begin
        r = $urandom_range(0, 99);
        if (burst_kind < 3)
          kind = (r < 80) ? KIND_ENQ : (r < 95) ? KIND_SRCH : KIND_STAT;
        else if (burst_kind < 5)
          kind = (r < 80) ? KIND_DEQ : (r < 95) ? KIND_SRCH : KIND_STAT;
        else
          kind = (r < 35) ? KIND_ENQ : (r < 65) ? KIND_DEQ : (r < 90) ? KIND_SRCH : KIND_STAT;
        send_request(kind, pick_value(kind));
        if (!sender_calm) idle_for(idle_length());
      end
    end

    idle_for(1);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.failures() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
